// ===== hw/rtl/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants of the curvature flux stencil
// Geometry defaults, register indexes, branch codes and the entry that
// travels from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 53;

  localparam logic [10:0] FrameWidthRst  = 11'd256;
  localparam logic [12:0] FrameHeightRst = 13'd256;
  localparam logic [7:0]  BandLimitRst   = 8'd8;
  localparam logic [40:0] MinGradSqRst   = 41'd67;
  localparam logic [52:0] MinNumRst      = 53'd67109;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BAND_LIMIT   = 3'd2,
    REG_MIN_GRAD_SQ  = 3'd3,
    REG_MIN_NUM      = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CASE_RATIO = 2'd0,
    CASE_ZERO  = 2'd1,
    CASE_HALF  = 2'd2
  } case_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_SUM,
    B_DEC,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [12:0] frame_height;
    logic [7:0]  band_limit;
    logic [40:0] min_grad_sq;
    logic [52:0] min_num;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         col;
    logic [11:0]        row;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [17:0] dxx;
    logic signed [17:0] dyy;
    logic signed [17:0] dxy;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csf_queue.sv =====
// ----------------------------------------------------------------------------
// csf_queue: two-entry queue between front end and back end
// Lets the stencil front end and the divider back end stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  csf_pkg::entry_t      entry_i,
  input  wire logic            pop_i,
  output csf_pkg::entry_t      entry_o,
  output csf_pkg::q_status_t   status_o
);

  csf_pkg::entry_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count beyond depth");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/csf_front.sv =====
// ----------------------------------------------------------------------------
// csf_front: line buffers, 3x3 window and pixel classification
// Tracks the raster position, keeps two rows in a memory, forms central
// differences of band pixels and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_front #(
  parameter int MAX_WIDTH  = csf_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = csf_pkg::MaxHeightDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  csf_pkg::cfg_t      cfg_i,
  input  wire logic          push_i,
  input  wire logic [15:0]   sample_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output csf_pkg::entry_t    q_entry_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [31:0]   line_mem [MAX_WIDTH];
  logic [31:0]   rd_q;
  logic [15:0]   win_q [6];
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          accept, interior, in_band;
  logic [15:0]   nt, nm;
  logic signed [17:0] xm1ym1, xm1y, xm1yp1, xym1, xy, xyp1, xp1ym1, xp1y, xp1yp1;
  logic signed [17:0] dx18, dy18, dxx, dyy, dxy;
  logic [16:0]   mag;

  function automatic logic signed [17:0] sx(input logic [15:0] v);
    return $signed({{2{v[15]}}, v});
  endfunction

  always_comb begin
    if (cfg_i.frame_width < 11'd3) begin
      w = WW'(3);
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height < 13'd3) begin
      h = HW'(3);
    end else if (32'(cfg_i.frame_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg_i.frame_height);
    end
  end

  assign accept = push_i && !q_full_i;
  assign nt = rd_q[31:16];
  assign nm = rd_q[15:0];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ((32'(col_q) + 32'd1) >= 32'(w)) begin
        col_d = '0;
        row_d = ((32'(row_q) + 32'd1) >= 32'(h)) ? '0 : RW'(32'(row_q) + 32'd1);
      end else begin
        col_d = CW'(32'(col_q) + 32'd1);
      end
    end
  end

  always_comb begin
    xym1   = sx(win_q[0]);
    xy     = sx(win_q[1]);
    xyp1   = sx(win_q[2]);
    xm1ym1 = sx(win_q[3]);
    xm1y   = sx(win_q[4]);
    xm1yp1 = sx(win_q[5]);
    xp1ym1 = sx(nt);
    xp1y   = sx(nm);
    xp1yp1 = sx(sample_i);
    dx18 = xp1y - xm1y;
    dy18 = xyp1 - xym1;
    dxx  = xp1y - (xy <<< 1) + xm1y;
    dyy  = xyp1 - (xy <<< 1) + xym1;
    dxy  = (xp1yp1 + xm1ym1) - (xp1ym1 + xm1yp1);
    mag  = xy[17] ? 17'(-xy) : 17'(xy);
    interior = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2) &&
               (32'(col_q) < 32'(w)) && (32'(row_q) < 32'(h));
    in_band  = mag < {1'b0, cfg_i.band_limit, 8'd0};
  end

  assign q_push_o = accept && interior && in_band;

  always_comb begin
    q_entry_o.col = 10'(32'(col_q) - 32'd1);
    q_entry_o.row = 12'(32'(row_q) - 32'd1);
    q_entry_o.dx  = dx18[16:0];
    q_entry_o.dy  = dy18[16:0];
    q_entry_o.dxx = dxx;
    q_entry_o.dyy = dyy;
    q_entry_o.dxy = dxy;
  end

  // prefetch the column of the next sample; a write never hits that column
  always_ff @(posedge clk_i) begin
    rd_q <= line_mem[col_d];
    if (accept) begin
      line_mem[col_q] <= {nm, sample_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= 16'd0;
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        win_q[3] <= win_q[0];
        win_q[4] <= win_q[1];
        win_q[5] <= win_q[2];
        win_q[0] <= nt;
        win_q[1] <= nm;
        win_q[2] <= sample_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csf_back.sv =====
// ----------------------------------------------------------------------------
// csf_back: curvature arithmetic, branch choice and divider
// Multiplies out the numerator and squared gradient, picks the branch,
// divides one quotient bit per cycle and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  csf_pkg::cfg_t           cfg_i,
  input  csf_pkg::entry_t         q_entry_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output logic [9:0]              col_o,
  output logic [11:0]             row_o,
  output logic signed [31:0]      flux_o,
  output logic [1:0]              case_taken_o
);

  localparam int NW = 62;
  localparam int DW = 34;

  csf_pkg::back_state_e state_q, state_d;
  csf_pkg::entry_t      e_q;
  logic signed [33:0]   pxx_q, pyy_q, pxy_q;
  logic signed [51:0]   t1_q, t2_q, t3_q;
  logic [DW-1:0]        g_q;
  logic signed [54:0]   num_q;
  logic [NW-1:0]        nrm_q;
  logic [DW-1:0]        rem_q;
  logic                 neg_q;
  logic [5:0]           cnt_q, cnt_d;
  logic signed [31:0]   res_flux_q;
  csf_pkg::case_e       res_case_q;
  logic                 ov_q, ov_d;
  logic signed [31:0]   flux_q;
  csf_pkg::case_e       case_q;
  logic [9:0]           col_q;
  logic [11:0]          row_q;

  logic signed [33:0] dx34, dy34;
  logic signed [54:0] num_d;
  logic [41:0]        g26;
  logic               c_ratio, c_zero;
  logic [54:0]        mag;
  logic [DW:0]        rem_sh;
  logic               ge;
  logic signed [63:0] quot;
  logic signed [18:0] lap;
  logic               load_out;

  assign dx34  = 34'(e_q.dx);
  assign dy34  = 34'(e_q.dy);
  assign num_d = (55'(t1_q) <<< 1) - 55'(t2_q) + (55'(t3_q) <<< 1);
  assign g26   = {g_q, 8'd0};
  assign c_ratio = (g26 > 42'(cfg_i.min_grad_sq)) && (g_q != '0);
  assign c_zero  = (g26 < 42'(cfg_i.min_grad_sq)) &&
                   (56'(num_q) < $signed({2'b00, cfg_i.min_num, 1'b0}));
  assign mag    = num_q[54] ? 55'(-num_q) : 55'(num_q);
  assign rem_sh = {rem_q, nrm_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, g_q};
  assign quot   = neg_q ? -$signed({2'b00, nrm_q}) : $signed({2'b00, nrm_q});
  assign lap    = 19'(e_q.dxx) + 19'(e_q.dyy);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      csf_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = csf_pkg::B_MUL1;
        end
      end
      csf_pkg::B_MUL1: state_d = csf_pkg::B_MUL2;
      csf_pkg::B_MUL2: state_d = csf_pkg::B_SUM;
      csf_pkg::B_SUM:  state_d = csf_pkg::B_DEC;
      csf_pkg::B_DEC: begin
        cnt_d   = '0;
        state_d = c_ratio ? csf_pkg::B_DIV : csf_pkg::B_OUT;
      end
      csf_pkg::B_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NW - 1)) begin
          state_d = csf_pkg::B_OUT;
        end
      end
      csf_pkg::B_OUT: begin
        if (!ov_q || pop_i) begin
          load_out = 1'b1;
          state_d  = csf_pkg::B_IDLE;
        end
      end
      default: state_d = csf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (pop_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csf_pkg::B_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      csf_pkg::B_IDLE: e_q <= q_entry_i;
      csf_pkg::B_MUL1: begin
        pxx_q <= dx34 * dx34;
        pyy_q <= dy34 * dy34;
        pxy_q <= dx34 * dy34;
      end
      csf_pkg::B_MUL2: begin
        t1_q <= 52'(e_q.dyy) * 52'(pxx_q);
        t2_q <= 52'(e_q.dxy) * 52'(pxy_q);
        t3_q <= 52'(e_q.dxx) * 52'(pyy_q);
        g_q  <= DW'(pxx_q + pyy_q);
      end
      csf_pkg::B_SUM: num_q <= num_d;
      csf_pkg::B_DEC: begin
        neg_q <= num_q[54];
        nrm_q <= {mag[54:0], 7'd0};
        rem_q <= '0;
        // record the branch taken; only the ratio branch goes on to the divider
        if (c_ratio) begin
          res_flux_q <= 32'sd0;
          res_case_q <= csf_pkg::CASE_RATIO;
        end else if (c_zero) begin
          res_flux_q <= 32'sd0;
          res_case_q <= csf_pkg::CASE_ZERO;
        end else begin
          res_flux_q <= csf_pkg::sat32(64'(lap) <<< 7);
          res_case_q <= csf_pkg::CASE_HALF;
        end
      end
      csf_pkg::B_DIV: begin
        rem_q <= ge ? DW'(rem_sh - {1'b0, g_q}) : rem_sh[DW-1:0];
        nrm_q <= {nrm_q[NW-2:0], ge};
      end
      csf_pkg::B_OUT: begin
        if (load_out) begin
          flux_q <= (res_case_q == csf_pkg::CASE_RATIO) ? csf_pkg::sat32(quot)
                                                        : res_flux_q;
          case_q <= res_case_q;
          col_q  <= e_q.col;
          row_q  <= e_q.row;
        end
      end
      default: ;
    endcase
  end

  assign empty_o      = !ov_q;
  assign flux_o       = flux_q;
  assign case_taken_o = case_q;
  assign col_o        = col_q;
  assign row_o        = row_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == csf_pkg::B_IDLE && !q_empty_i))
    else $error("queue popped outside idle");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csf_pkg::B_DIV) |-> (cnt_q < 6'(NW)))
    else $error("divider ran past its length");
  a_zero_flux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && case_q == csf_pkg::CASE_ZERO) |-> (flux_q == 32'sd0))
    else $error("zero branch with nonzero flux");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!ov_q || pop_i))
    else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/curvature_flux_stencil_core.sv =====
// ----------------------------------------------------------------------------
// curvature_flux_stencil_core: level-set mean curvature flux over 3x3 window
// Front end streams samples through line buffers; back end computes the
// flux of each interior band pixel and presents it as a queue.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  input    | in        | push / full          | sample_i
//  result   | out       | pop / empty          | col_o, row_o, flux_o, case_taken_o
//  config   | in        | cfg_valid_i / ready  | cfg_index_i, cfg_data_i
//
// Samples are taken one per cycle while the front queue has room; a sample
// outside the interior or band is still taken but gives no result.
// A band pixel passes the back-end states idle, multiply, sum and decide, then
// the divider in the ratio branch (one quotient bit per cycle), then output.
// Reset clears counters, window and queues; the line store needs no clearing.
// The back end takes a new pixel only after output, and a held result that is not popped holds it there.
// ----------------------------------------------------------------------------
`default_nettype none

module curvature_flux_stencil_core #(
  parameter int MAX_WIDTH  = csf_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = csf_pkg::MaxHeightDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [15:0]           sample_i,
  input  wire logic                         pop,
  output logic                              empty,
  output logic [9:0]                        col_o,
  output logic [11:0]                       row_o,
  output logic signed [31:0]                flux_o,
  output logic [1:0]                        case_taken_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [csf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [csf_pkg::CfgDataW-1:0] cfg_data_i
);

  csf_pkg::cfg_t      cfg_q;
  csf_pkg::entry_t    f_entry, b_entry;
  csf_pkg::q_status_t q_status;
  logic               f_push, b_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= csf_pkg::FrameWidthRst;
      cfg_q.frame_height <= csf_pkg::FrameHeightRst;
      cfg_q.band_limit   <= csf_pkg::BandLimitRst;
      cfg_q.min_grad_sq  <= csf_pkg::MinGradSqRst;
      cfg_q.min_num      <= csf_pkg::MinNumRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        csf_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[10:0];
        csf_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[12:0];
        csf_pkg::REG_BAND_LIMIT:   cfg_q.band_limit   <= cfg_data_i[7:0];
        csf_pkg::REG_MIN_GRAD_SQ:  cfg_q.min_grad_sq  <= cfg_data_i[40:0];
        csf_pkg::REG_MIN_NUM:      cfg_q.min_num      <= cfg_data_i[52:0];
        default: ;
      endcase
    end
  end

  assign full = q_status.full;

  csf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .sample_i  (sample_i),
    .q_full_i  (q_status.full),
    .q_push_o  (f_push),
    .q_entry_o (f_entry)
  );

  csf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (f_push),
    .entry_i  (f_entry),
    .pop_i    (b_pop),
    .entry_o  (b_entry),
    .status_o (q_status)
  );

  csf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_entry_i    (b_entry),
    .q_empty_i    (q_status.empty),
    .q_pop_o      (b_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .col_o        (col_o),
    .row_o        (row_o),
    .flux_o       (flux_o),
    .case_taken_o (case_taken_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_curvature_flux_stencil_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_curvature_flux_stencil_core: self-checking bench of the flux stencil
// Streams whole frames of samples through the core under several register
// settings. A scoreboard model of the line buffers, the window and the flux
// arithmetic predicts every result, and each popped result is checked
// field by field against the oldest prediction. Both sides idle in random
// bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_curvature_flux_stencil_core;

  localparam int MaxW = csf_pkg::MaxWidthDef;
  localparam int MaxH = csf_pkg::MaxHeightDef;
  localparam logic [csf_pkg::CfgIdxW-1:0] RegUnused = 3'd5;
  localparam int CycleLimit = 3000000;
  localparam int DrainWait = 200;

  typedef struct {
    logic [9:0]         col;
    logic [11:0]        row;
    logic signed [31:0] flux;
    csf_pkg::case_e     kind;
  } flux_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic pop = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [csf_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [csf_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic full, empty, cfg_ready_o;
  logic [9:0] col_o;
  logic [11:0] row_o;
  logic signed [31:0] flux_o;
  logic [1:0] case_taken_o;

  curvature_flux_stencil_core dut (
    .clk_i, .rst_ni, .push, .full, .sample_i, .pop, .empty,
    .col_o, .row_o, .flux_o, .case_taken_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // scoreboard model state
  logic [15:0] lines_m [2*MaxW];
  logic [15:0] win_m [6];
  int unsigned col_m, row_m;
  logic [10:0] width_m = csf_pkg::FrameWidthRst;
  logic [12:0] height_m = csf_pkg::FrameHeightRst;
  logic [7:0]  band_m = csf_pkg::BandLimitRst;
  logic [40:0] gmin_m = csf_pkg::MinGradSqRst;
  logic [52:0] nmin_m = csf_pkg::MinNumRst;

  flux_res_t flux_exp_q[$];
  logic signed [15:0] pending_q[$];
  int errors = 0;
  int n_taken = 0;
  logic in_taken = 1'b0;
  logic quiet = 1'b0;
  logic long_hold_done = 1'b0;
  int cycles = 0;

  task automatic stencil_step(input logic [15:0] nb);
    int unsigned w, h, c, r;
    logic [15:0] nt, nm;
    longint xm1ym1, xm1y, xm1yp1, xym1, xy, xyp1, xp1ym1, xp1y, xp1yp1, mag;
    longint dx, dy, dxx, dyy, dxy, num27, fl;
    logic [63:0] g18, g26;
    flux_res_t res;
    w = (width_m < 3) ? 3 : (width_m > MaxW) ? MaxW : width_m;
    h = (height_m < 3) ? 3 : (height_m > MaxH) ? MaxH : height_m;
    c = col_m % MaxW;
    r = row_m;
    nt = lines_m[MaxW + c];
    nm = lines_m[c];
    lines_m[MaxW + c] = nm;
    lines_m[c] = nb;
    if (r >= 2 && c >= 2 && c < w && r < h) begin
      xm1ym1 = $signed(win_m[3]); xm1y = $signed(win_m[4]); xm1yp1 = $signed(win_m[5]);
      xym1 = $signed(win_m[0]);   xy = $signed(win_m[1]);   xyp1 = $signed(win_m[2]);
      xp1ym1 = $signed(nt);       xp1y = $signed(nm);       xp1yp1 = $signed(nb);
      mag = (xy < 0) ? -xy : xy;
      if (mag < longint'(band_m) * 256) begin
        dx = xp1y - xm1y;
        dy = xyp1 - xym1;
        dxx = xp1y - 2 * xy + xm1y;
        dyy = xyp1 - 2 * xy + xym1;
        dxy = (xp1yp1 + xm1ym1) - (xp1ym1 + xm1yp1);
        num27 = 2 * dyy * dx * dx - dx * dy * dxy + 2 * dxx * dy * dy;
        g18 = dx * dx + dy * dy;
        g26 = g18 * 256;
        if (g26 > {23'd0, gmin_m} && g18 != 0) begin
          fl = (num27 * 128) / longint'(g18);
          res.kind = csf_pkg::CASE_RATIO;
        end else if (g26 < {23'd0, gmin_m} && num27 < 2 * longint'(nmin_m)) begin
          fl = 0;
          res.kind = csf_pkg::CASE_ZERO;
        end else begin
          fl = (dxx + dyy) * 128;
          res.kind = csf_pkg::CASE_HALF;
        end
        if (fl > 64'sd2147483647) fl = 64'sd2147483647;
        if (fl < -64'sd2147483648) fl = -64'sd2147483648;
        res.col = 10'(c - 1);
        res.row = 12'(r - 1);
        res.flux = fl[31:0];
        flux_exp_q.push_back(res);
      end
    end
    win_m[3] = win_m[0]; win_m[4] = win_m[1]; win_m[5] = win_m[2];
    win_m[0] = nt;       win_m[1] = nm;       win_m[2] = nb;
    if (c + 1 >= w) begin
      col_m = 0;
      row_m = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_m = c + 1;
    end
  endtask

  // monitor: input acceptance feeds the model, then check popped results
  always @(posedge clk_i) begin
    flux_res_t e;
    cycles <= cycles + 1;
    in_taken <= push && !full;
    if (push && !full) begin
      stencil_step(sample_i);
      n_taken <= n_taken + 1;
    end
    if (pop && !empty) begin
      if (flux_exp_q.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d flux=%0d case=%0d", $time,
                 col_o, row_o, flux_o, case_taken_o);
        errors <= errors + 1;
      end else begin
        e = flux_exp_q.pop_front();
        if (col_o !== e.col || row_o !== e.row || flux_o !== e.flux ||
            case_taken_o !== e.kind) begin
          $display("%0t: mismatch expected col=%0d row=%0d flux=%0d case=%0d",
                   $time, e.col, e.row, e.flux, e.kind);
          $display("%0t:          actual   col=%0d row=%0d flux=%0d case=%0d",
                   $time, col_o, row_o, flux_o, case_taken_o);
          errors <= errors + 1;
        end
      end
    end
  end

  // driver: present pending samples, hold a sample until it is taken
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (in_taken) void'(pending_q.pop_front());
    if (push && !in_taken) begin
      // hold the offered transaction
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      push <= 1'b0;
    end else if (pending_q.size() > 0) begin
      if (!quiet && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(0, 9);
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        sample_i <= pending_q[0];
      end
    end else begin
      push <= 1'b0;
    end
  end

  // receiver: random idle bursts and one long hold-off
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      pop <= 1'b0;
    end else if (!long_hold_done && n_taken >= 300 && flux_exp_q.size() > 0) begin
      long_hold_done <= 1'b1;
      recv_gap <= 600;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      recv_gap <= $urandom_range(0, 9);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || push || flux_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [csf_pkg::CfgIdxW-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[csf_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      csf_pkg::REG_FRAME_WIDTH:  width_m = data[10:0];
      csf_pkg::REG_FRAME_HEIGHT: height_m = data[12:0];
      csf_pkg::REG_BAND_LIMIT:   band_m = data[7:0];
      csf_pkg::REG_MIN_GRAD_SQ:  gmin_m = data[40:0];
      csf_pkg::REG_MIN_NUM:      nmin_m = data[52:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int band);
    write_reg(csf_pkg::REG_FRAME_WIDTH, w);
    write_reg(csf_pkg::REG_FRAME_HEIGHT, h);
    write_reg(csf_pkg::REG_BAND_LIMIT, band);
  endtask

  function automatic logic [63:0] pick_thresh(input int bits);
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 64'd1 << (bits - 1);
      2: v = $urandom_range(0, 200);
      3: v = {$urandom, $urandom} & ((64'd1 << $urandom_range(4, bits)) - 1);
      default: v = $urandom_range(1000, 100000);
    endcase
    return v;
  endfunction

  // queue whole frames at the current geometry
  task automatic queue_frames(input int nframes);
    int w, h, lim;
    logic signed [15:0] v, prev;
    w = (width_m < 3) ? 3 : (width_m > MaxW) ? MaxW : width_m;
    h = (height_m < 3) ? 3 : (height_m > MaxH) ? MaxH : height_m;
    lim = band_m * 256;
    prev = 0;
    for (int i = 0; i < nframes * w * h; i++) begin
      case ($urandom_range(0, 9))
        0, 1: v = 16'($urandom);
        2:    v = prev;
        3:    v = prev + $signed(16'($urandom_range(0, 6)) - 16'sd3);
        default: v = (lim == 0) ? 16'sd0 : 16'($urandom_range(0, 2 * lim) - lim);
      endcase
      pending_q.push_back(v);
      prev = v;
    end
  endtask

  initial begin
    logic signed [15:0] corner [25];
    int items;
    for (int i = 0; i < 2 * MaxW; i++) lines_m[i] = '0;
    for (int i = 0; i < 6; i++) win_m[i] = '0;
    col_m = 0;
    row_m = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // field extremes, band limit 128, zero thresholds
    set_geometry(5, 5, 128);
    write_reg(csf_pkg::REG_MIN_GRAD_SQ, 0);
    write_reg(csf_pkg::REG_MIN_NUM, 0);
    write_reg(RegUnused, 64'h1234);
    corner = '{16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh0000, -16'sh8000,
               -16'sh8000, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000,
               16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh0000,
               16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff,
               16'sh1234, -16'sh7fff, 16'sh0001, -16'sh0001, 16'sh5555};
    foreach (corner[i]) pending_q.push_back(corner[i]);
    wait_idle();
    // band edge samples: gradient below the threshold and the zero branch
    write_reg(csf_pkg::REG_BAND_LIMIT, 1);
    write_reg(csf_pkg::REG_MIN_GRAD_SQ, 64'd1 << 40);
    write_reg(csf_pkg::REG_MIN_NUM, 64'd1 << 52);
    for (int i = 0; i < 25; i++)
      pending_q.push_back((i % 3 == 0) ? 16'sd255 : (i % 3 == 1) ? 16'sd256 : -16'sd256);
    wait_idle();

    // random settings, whole frames
    items = 50;
    while (items < 800) begin
      set_geometry($urandom_range(3, 20), $urandom_range(3, 12),
                   ($urandom_range(0, 5) == 0) ? 128 : $urandom_range(1, 40));
      write_reg(csf_pkg::REG_MIN_GRAD_SQ, pick_thresh(41));
      write_reg(csf_pkg::REG_MIN_NUM, pick_thresh(53));
      if (items > 650) quiet = 1'b1;
      queue_frames(1);
      items += pending_q.size();
      wait_idle();
    end

    // geometry below the minimum clamps to three by three
    set_geometry(0, 1, 2);
    queue_frames(1);
    wait_idle();
    set_geometry(3, 3, 128);
    write_reg(csf_pkg::REG_MIN_GRAD_SQ, 67);
    queue_frames(4);
    wait_idle();

    if (errors == 0 && flux_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
